// ----- rtl/core/pcxrle_pkg.sv -----
package pcxrle_pkg;

   // Default scanline dimension width
   localparam int DIM_BITS_DEF = 16;

   // Count code: both top bits set, count in the low six bits
   localparam logic [1:0] RUN_FLAG   = 2'b11;
   localparam int         COUNT_BITS = 6;
   localparam logic [COUNT_BITS-1:0] COUNT_MASK = 6'h3F;

   // CSR register indexes (byte address 4*i)
   localparam int         CSR_ADDR_BITS = 4;
   localparam logic [1:0] REG_BYTES_PER_LINE = 2'd0;
   localparam logic [1:0] REG_VISIBLE_WIDTH  = 2'd1;
   localparam logic [1:0] REG_LINE_COUNT     = 2'd2;

   // Flags from the position step unit
   typedef struct packed {
      logic line_end;
      logic image_end;
      logic visible;
      logic eol;
      logic eoi;
   } step_flags_type;

endpackage

// ----- rtl/core/pcxrle_if.sv -----
interface pcxrle_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] code_byte;

   modport source (output valid, output code_byte, input ready);
   modport sink   (input valid, input code_byte, output ready);
endinterface

interface pcxrle_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel;
   logic       end_of_line;
   logic       end_of_image;
   logic       last;

   modport source (output valid, output pixel, output end_of_line, output end_of_image,
                   output last, input ready);
   modport sink   (input valid, input pixel, input end_of_line, input end_of_image,
                   input last, output ready);
endinterface

// ----- rtl/core/pcxrle_csr.sv -----
module pcxrle_csr #(
   parameter int DIM_BITS = pcxrle_pkg::DIM_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [pcxrle_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]                          csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready,
   output logic [DIM_BITS-1:0]                  bpl_eff,
   output logic [DIM_BITS-1:0]                  vis_eff,
   output logic [DIM_BITS-1:0]                  lines
);
   import pcxrle_pkg::*;

   localparam logic [DIM_BITS-1:0] ONE = DIM_BITS'(1);

   logic [DIM_BITS-1:0] bpl_ff, bpl_in;
   logic [DIM_BITS-1:0] vis_ff, vis_in;
   logic [DIM_BITS-1:0] lines_ff, lines_in;
   logic                wr_en;
   logic [1:0]          idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign idx        = csr_paddr[3:2];

   always_comb begin
      bpl_in   = bpl_ff;
      vis_in   = vis_ff;
      lines_in = lines_ff;
      if (wr_en) begin
         case (idx)
            REG_BYTES_PER_LINE: bpl_in   = csr_pwdata[DIM_BITS-1:0];
            REG_VISIBLE_WIDTH:  vis_in   = csr_pwdata[DIM_BITS-1:0];
            REG_LINE_COUNT:     lines_in = csr_pwdata[DIM_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpl_ff   <= ONE;
         vis_ff   <= ONE;
         lines_ff <= ONE;
      end else begin
         bpl_ff   <= bpl_in;
         vis_ff   <= vis_in;
         lines_ff <= lines_in;
      end
   end

   always_comb begin
      case (idx)
         REG_BYTES_PER_LINE: csr_prdata = 32'(bpl_ff);
         REG_VISIBLE_WIDTH:  csr_prdata = 32'(vis_ff);
         REG_LINE_COUNT:     csr_prdata = 32'(lines_ff);
         default:            csr_prdata = 32'd0;
      endcase
   end

   // zero width acts as one position; visible width clamped to line
   assign bpl_eff = (bpl_ff == '0) ? ONE : bpl_ff;
   assign vis_eff = (vis_ff < bpl_eff) ? vis_ff : bpl_eff;
   assign lines   = lines_ff;

endmodule

// ----- rtl/core/pcxrle_step.sv -----
module pcxrle_step #(
   parameter int DIM_BITS = pcxrle_pkg::DIM_BITS_DEF
) (
   input  logic [DIM_BITS-1:0]       column,
   input  logic [DIM_BITS-1:0]       row,
   input  logic [DIM_BITS-1:0]       bpl_eff,
   input  logic [DIM_BITS-1:0]       vis_eff,
   input  logic [DIM_BITS-1:0]       lines,
   output pcxrle_pkg::step_flags_type flags,
   output logic [DIM_BITS-1:0]       next_column,
   output logic [DIM_BITS-1:0]       next_row
);
   import pcxrle_pkg::*;

   logic [DIM_BITS:0] col1;
   logic [DIM_BITS:0] row1;
   logic              last_row;

   assign col1     = {1'b0, column} + (DIM_BITS+1)'(1);
   assign row1     = {1'b0, row} + (DIM_BITS+1)'(1);
   assign last_row = row1 >= {1'b0, lines};

   always_comb begin
      flags.line_end  = col1 >= {1'b0, bpl_eff};
      flags.image_end = flags.line_end && last_row;
      flags.visible   = column < vis_eff;
      flags.eol       = col1 >= {1'b0, vis_eff};
      flags.eoi       = flags.eol && last_row;
   end

   assign next_column = flags.line_end ? '0 : col1[DIM_BITS-1:0];
   assign next_row    = flags.line_end ? row1[DIM_BITS-1:0] : row;

endmodule

// ----- rtl/core/pcx_rle_scanline_decoder.sv -----
// PCX run-length scanline decoder, 8-bit pixels. One compressed byte per req
// beat; each visible decoded pixel leaves as one rsp beat with end-of-line,
// end-of-image and last-of-byte marks. A count code (top two bits set) yields
// nothing; the following value byte is expanded by a sequencer that steps one
// shared position unit (column/row add and compare) once per copy (1..63),
// and no new byte is accepted until its copies are done. Padding copies past
// visible_width still step the position unit. Runs are cut at the end of a
// line; bytes after the last line are accepted and dropped. An rsp beat
// waiting in the output register does not block acceptance of the next
// byte, only the next copy.
// Registers (APB, byte address 4*i): 0 bytes_per_line, 1 visible_width,
// 2 line_count, all reset to 1; write only while the decoder is idle.
module pcx_rle_scanline_decoder #(
   parameter int DIM_BITS = pcxrle_pkg::DIM_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   pcxrle_req_if.sink                           req_bus,
   pcxrle_rsp_if.source                         rsp_bus,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [pcxrle_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]                          csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);
   import pcxrle_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   // config
   logic [DIM_BITS-1:0] bpl_eff;
   logic [DIM_BITS-1:0] vis_eff;
   logic [DIM_BITS-1:0] lines;

   // sequencer state
   logic                  state_ff, state_in;
   logic                  awaiting_ff, awaiting_in;
   logic [COUNT_BITS-1:0] pending_ff, pending_in;
   logic [COUNT_BITS-1:0] left_ff, left_in;
   logic [DIM_BITS-1:0]   column_ff, column_in;
   logic [DIM_BITS-1:0]   row_ff, row_in;
   logic                  finished_ff, finished_in;
   logic [7:0]            byte_ff, byte_in;

   // output register
   logic       ovalid_ff, ovalid_in;
   logic [7:0] opixel_ff, opixel_in;
   logic       oeol_ff, oeol_in;
   logic       oeoi_ff, oeoi_in;
   logic       olast_ff, olast_in;

   step_flags_type      flags;
   logic [DIM_BITS-1:0] next_column;
   logic [DIM_BITS-1:0] next_row;
   logic                accept;
   logic                advance;
   logic                last_copy;

   pcxrle_csr #(.DIM_BITS(DIM_BITS)) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .bpl_eff     (bpl_eff),
      .vis_eff     (vis_eff),
      .lines       (lines)
   );

   // shared position unit, one copy per use
   pcxrle_step #(.DIM_BITS(DIM_BITS)) u_step (
      .column      (column_ff),
      .row         (row_ff),
      .bpl_eff     (bpl_eff),
      .vis_eff     (vis_eff),
      .lines       (lines),
      .flags       (flags),
      .next_column (next_column),
      .next_row    (next_row)
   );

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   // a copy proceeds only when the output register can take its beat
   assign advance       = (state_ff == ST_RUN) && (!ovalid_ff || rsp_bus.ready);
   assign last_copy     = (left_ff == COUNT_BITS'(1));

   always_comb begin
      state_in    = state_ff;
      awaiting_in = awaiting_ff;
      pending_in  = pending_ff;
      left_in     = left_ff;
      column_in   = column_ff;
      row_in      = row_ff;
      finished_in = finished_ff;
      byte_in     = byte_ff;
      ovalid_in   = ovalid_ff && !rsp_bus.ready;
      opixel_in   = opixel_ff;
      oeol_in     = oeol_ff;
      oeoi_in     = oeoi_ff;
      olast_in    = olast_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept && !finished_ff && (lines != '0)) begin
               if (!awaiting_ff && (req_bus.code_byte[7:6] == RUN_FLAG)) begin
                  awaiting_in = 1'b1;
                  pending_in  = req_bus.code_byte[COUNT_BITS-1:0] & COUNT_MASK;
               end else begin
                  // count of zero still gives one copy
                  if (awaiting_ff && (pending_ff != '0))
                     left_in = pending_ff;
                  else
                     left_in = COUNT_BITS'(1);
                  awaiting_in = 1'b0;
                  pending_in  = '0;
                  byte_in     = req_bus.code_byte;
                  state_in    = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (advance) begin
               if (flags.visible) begin
                  ovalid_in = 1'b1;
                  opixel_in = byte_ff;
                  oeol_in   = flags.eol;
                  oeoi_in   = flags.eoi;
                  // nothing visible follows after eol or the line end
                  olast_in  = last_copy || flags.line_end || flags.eol;
               end
               column_in = next_column;
               row_in    = next_row;
               if (flags.image_end)
                  finished_in = 1'b1;
               left_in = left_ff - COUNT_BITS'(1);
               if (last_copy || flags.line_end)
                  state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         awaiting_ff <= 1'b0;
         pending_ff  <= '0;
         left_ff     <= '0;
         column_ff   <= '0;
         row_ff      <= '0;
         finished_ff <= 1'b0;
         ovalid_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         awaiting_ff <= awaiting_in;
         pending_ff  <= pending_in;
         left_ff     <= left_in;
         column_ff   <= column_in;
         row_ff      <= row_in;
         finished_ff <= finished_in;
         ovalid_ff   <= ovalid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      opixel_ff <= opixel_in;
      oeol_ff   <= oeol_in;
      oeoi_ff   <= oeoi_in;
      olast_ff  <= olast_in;
   end

   assign rsp_bus.valid        = ovalid_ff;
   assign rsp_bus.pixel        = opixel_ff;
   assign rsp_bus.end_of_line  = oeol_ff;
   assign rsp_bus.end_of_image = oeoi_ff;
   assign rsp_bus.last         = olast_ff;

endmodule
